// ===== rtl/spl_pkg.sv =====
// Shared types and constants of the setpoint limiter.
// Used by spl_ctrl, spl_datapath and the top level; depends on nothing.
`default_nettype none

package spl_pkg;

  // Configuration register indexes
  localparam int CFG_AW = 3;
  typedef enum logic [CFG_AW-1:0] {
    CFG_PERIOD         = 3'd0,
    CFG_TWO_OVER_PSQ   = 3'd1,
    CFG_HALF_PSQ       = 3'd2,
    CFG_ACCEL_LIMIT    = 3'd3,
    CFG_VELOCITY_LIMIT = 3'd4
  } cfg_idx_t;

  // Register reset values
  localparam logic [30:0] PERIOD_RST         = 31'd838861;
  localparam logic [31:0] TWO_OVER_PSQ_RST   = 32'd52428800;
  localparam logic [30:0] HALF_PSQ_RST       = 31'd20972;
  localparam logic [30:0] ACCEL_LIMIT_RST    = 31'd838861;
  localparam logic [30:0] VELOCITY_LIMIT_RST = 31'd1677722;

  // Datapath widths
  localparam int POS_W   = 32;  // Q8.24 field
  localparam int NPROD_W = 64;  // 32x32 product
  localparam int VDT_W   = 40;  // v*dt after the 24-bit shift
  localparam int DIFF_W  = 41;  // target - measured - v*dt
  localparam int KH_W    = 17;  // one 16-bit half of 2/dt^2, signed
  localparam int WPROD_W = 58;  // DIFF_W x KH_W product
  localparam int ASUM_W  = 59;  // high product plus shifted low product
  localparam int VN_W    = 41;  // v + a*dt before clamping
  localparam int SP_W    = 42;  // setpoint sum before saturation

  typedef struct packed {
    logic [30:0] period;
    logic [31:0] two_over_period_sq;
    logic [30:0] half_period_sq;
    logic [30:0] accel_limit;
    logic [30:0] velocity_limit;
  } spl_cfg_t;

  // One strobe per datapath step
  typedef struct packed {
    logic load;
    logic vdt;
    logic diff;
    logic khi;
    logic klo;
    logic acc;
    logic vel;
    logic spt;
    logic fin;
  } spl_cmd_t;

  typedef struct packed {
    logic axis_ok;
    logic out_free;
  } spl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/spl_ctrl.sv =====
// Step sequencer of the setpoint limiter.
// Depends on spl_pkg; drives the command strobes of spl_datapath.
`default_nettype none

module spl_ctrl
  import spl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire spl_sts_t sts,
  output spl_cmd_t      cmd
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_VDT  = 9'b000000010,
    ST_DIFF = 9'b000000100,
    ST_KHI  = 9'b000001000,
    ST_KLO  = 9'b000010000,
    ST_ACC  = 9'b000100000,
    ST_VEL  = 9'b001000000,
    ST_SPT  = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          // drop items for axes that do not exist
          if (sts.axis_ok) state_nxt = ST_VDT;
        end
      end
      ST_VDT: begin
        cmd.vdt   = 1'b1;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_KHI;
      end
      ST_KHI: begin
        cmd.khi   = 1'b1;
        state_nxt = ST_KLO;
      end
      ST_KLO: begin
        cmd.klo   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = ST_VEL;
      end
      ST_VEL: begin
        cmd.vel   = 1'b1;
        state_nxt = ST_SPT;
      end
      ST_SPT: begin
        cmd.spt   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spl_datapath.sv =====
// Datapath of the setpoint limiter: velocity store, two shared multipliers,
// clamps and the output register. Depends on spl_pkg; steered by spl_ctrl.
`default_nettype none

module spl_datapath
  import spl_pkg::*;
#(
  parameter int AXES = 6,
  parameter int AXW  = 3
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire spl_cfg_t                cfg,
  input  wire spl_cmd_t                cmd,
  output spl_sts_t                     sts,
  input  wire logic        [2:0]       in_axis,
  input  wire logic signed [POS_W-1:0] in_meas,
  input  wire logic signed [POS_W-1:0] in_targ,
  input  wire logic                    out_ready,
  output logic                         out_valid,
  output logic             [2:0]       out_axis,
  output logic signed      [POS_W-1:0] out_setpoint,
  output logic signed      [POS_W-1:0] out_velocity,
  output logic signed      [POS_W-1:0] out_accel
);

  localparam logic [4:0] AXES_L = 5'(AXES);
  localparam logic signed [SP_W-1:0] SP_MAX = SP_W'(64'sd2147483647);
  localparam logic signed [SP_W-1:0] SP_MIN = SP_W'(-64'sd2147483648);

  logic signed [POS_W-1:0]   vel_r [AXES];
  logic        [2:0]         axis_r;
  logic signed [POS_W-1:0]   meas_r, targ_r, v0_r, a_r;
  logic signed [NPROD_W-1:0] pn_r, ps_r;
  logic signed [VDT_W-1:0]   vdt_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [WPROD_W-1:0] phi_r, plo_r;
  logic                      out_valid_r;
  logic        [2:0]         out_axis_r;
  logic signed [POS_W-1:0]   out_sp_r, out_vel_r, out_acc_r;

  logic        [4:0]         in_axis_ext, axis_r_ext;
  logic signed [POS_W-1:0]   mn_a, mn_b;
  logic signed [NPROD_W-1:0] mn_prod;
  logic signed [KH_W-1:0]    mw_b;
  logic signed [WPROD_W-1:0] mw_prod;
  logic signed [VDT_W-1:0]   vdt_c;
  logic signed [DIFF_W-1:0]  diff_c;
  logic signed [ASUM_W-1:0]  asum_c, alim_c, aclp_c;
  logic signed [VN_W-1:0]    vsum_c, vlim_c, vclp_c;
  logic signed [SP_W-1:0]    spsum_c, spsat_c;

  assign in_axis_ext = {2'b00, in_axis};
  assign axis_r_ext  = {2'b00, axis_r};

  assign sts.axis_ok  = (in_axis_ext < AXES_L);
  assign sts.out_free = !out_valid_r || out_ready;

  // 32x32 unit: v0*dt, then a*dt and a*dt^2/2
  assign mn_a    = cmd.vdt ? v0_r : a_r;
  assign mn_b    = cmd.spt ? $signed({1'b0, cfg.half_period_sq}) : $signed({1'b0, cfg.period});
  assign mn_prod = mn_a * mn_b;

  // 41x17 unit: error times the high, then the low half of 2/dt^2
  assign mw_b    = cmd.klo ? $signed({1'b0, cfg.two_over_period_sq[15:0]})
                           : $signed({1'b0, cfg.two_over_period_sq[31:16]});
  assign mw_prod = diff_r * mw_b;

  always_comb begin
    vdt_c  = $signed(pn_r[NPROD_W-1:24]);
    diff_c = DIFF_W'(targ_r) - DIFF_W'(meas_r) - DIFF_W'(vdt_c);

    asum_c = ASUM_W'(phi_r) + ASUM_W'($signed(plo_r[WPROD_W-1:16]));
    alim_c = $signed(ASUM_W'(cfg.accel_limit));
    if (asum_c > alim_c) begin
      aclp_c = alim_c;
    end else if (asum_c < -alim_c) begin
      aclp_c = -alim_c;
    end else begin
      aclp_c = asum_c;
    end

    vsum_c = VN_W'(v0_r) + VN_W'($signed(pn_r[NPROD_W-1:24]));
    vlim_c = $signed(VN_W'(cfg.velocity_limit));
    if (vsum_c > vlim_c) begin
      vclp_c = vlim_c;
    end else if (vsum_c < -vlim_c) begin
      vclp_c = -vlim_c;
    end else begin
      vclp_c = vsum_c;
    end

    spsum_c = SP_W'(meas_r) + SP_W'(vdt_r) + SP_W'($signed(ps_r[NPROD_W-1:24]));
    if (spsum_c > SP_MAX) begin
      spsat_c = SP_MAX;
    end else if (spsum_c < SP_MIN) begin
      spsat_c = SP_MIN;
    end else begin
      spsat_c = spsum_c;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      axis_r <= in_axis;
      meas_r <= in_meas;
      targ_r <= in_targ;
      v0_r   <= vel_r[in_axis_ext[AXW-1:0]];
    end
    if (cmd.vdt || cmd.vel) pn_r <= mn_prod;
    if (cmd.spt)            ps_r <= mn_prod;
    if (cmd.diff) begin
      vdt_r  <= vdt_c;
      diff_r <= diff_c;
    end
    if (cmd.khi) phi_r <= mw_prod;
    if (cmd.klo) plo_r <= mw_prod;
    if (cmd.acc) a_r   <= $signed(aclp_c[POS_W-1:0]);
    if (cmd.fin) begin
      out_axis_r <= axis_r;
      out_sp_r   <= $signed(spsat_c[POS_W-1:0]);
      out_vel_r  <= $signed(vclp_c[POS_W-1:0]);
      out_acc_r  <= a_r;
    end
  end

  // Per-axis velocity, zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        vel_r[i] <= '0;
      end
    end else if (cmd.fin) begin
      vel_r[axis_r_ext[AXW-1:0]] <= $signed(vclp_c[POS_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_axis     = out_axis_r;
  assign out_setpoint = out_sp_r;
  assign out_velocity = out_vel_r;
  assign out_accel    = out_acc_r;

endmodule

`default_nettype wire

// ===== rtl/axis_setpoint_accel_vel_limiter.sv =====
// Top level of the acceleration- and velocity-limited setpoint generator:
// configuration registers, spl_ctrl and spl_datapath. Depends on spl_pkg.
//
//   port group | direction | tdata / payload                        | tuser
//   in_        | slave     | measured_position, target_position     | axis
//   out_       | master    | setpoint, velocity, acceleration       | axis_out
//   cfg_       | write     | register value, index in cfg_addr      | -
//
// An item for an existing axis goes from accept to the next accept through an
// accept step and eight datapath steps, set by the 32x32 multiplier being
// used three times and the 41x17 multiplier twice, one product per cycle. An
// item whose axis is AXES or more is taken and dropped without a result.
// Synchronous reset clears the per-axis velocities and loads the register
// defaults. A stalled result waits in the output register while the next item
// is accepted; the last step waits there if that register is still full.
`default_nettype none

module axis_setpoint_accel_vel_limiter
  import spl_pkg::*;
#(
  parameter int AXES = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [63:0]       in_tdata,   // measured_position, target_position
  input  wire logic [2:0]        in_tuser,   // axis
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [95:0]       out_tdata,  // setpoint, velocity, acceleration
  output logic      [2:0]        out_tuser,  // axis_out
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [31:0]       cfg_wdata
);

  localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;

  spl_cfg_t cfg_r;
  spl_cmd_t cmd;
  spl_sts_t sts;
  logic signed [POS_W-1:0] sp_w, vel_w, acc_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period             <= PERIOD_RST;
      cfg_r.two_over_period_sq <= TWO_OVER_PSQ_RST;
      cfg_r.half_period_sq     <= HALF_PSQ_RST;
      cfg_r.accel_limit        <= ACCEL_LIMIT_RST;
      cfg_r.velocity_limit     <= VELOCITY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_PERIOD:         cfg_r.period             <= cfg_wdata[30:0];
        CFG_TWO_OVER_PSQ:   cfg_r.two_over_period_sq <= cfg_wdata;
        CFG_HALF_PSQ:       cfg_r.half_period_sq     <= cfg_wdata[30:0];
        CFG_ACCEL_LIMIT:    cfg_r.accel_limit        <= cfg_wdata[30:0];
        CFG_VELOCITY_LIMIT: cfg_r.velocity_limit     <= cfg_wdata[30:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  spl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spl_datapath #(
    .AXES (AXES),
    .AXW  (AXW)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .cmd          (cmd),
    .sts          (sts),
    .in_axis      (in_tuser),
    .in_meas      ($signed(in_tdata[31:0])),
    .in_targ      ($signed(in_tdata[63:32])),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_axis     (out_tuser),
    .out_setpoint (sp_w),
    .out_velocity (vel_w),
    .out_accel    (acc_w)
  );

  assign out_tdata = {acc_w, vel_w, sp_w};

  // An accepted item for an existing axis occupies the sequencer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && ({2'b00, in_tuser} < 5'(AXES))) |=> !in_tready)
    else $error("in_tready high right after accepting an in-range item");

  a_vel_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed({vel_w[31], vel_w}) <= $signed({2'b00, cfg_r.velocity_limit})) &&
      ($signed({vel_w[31], vel_w}) >= -$signed({2'b00, cfg_r.velocity_limit})))
    else $error("velocity result outside the velocity limit");

  a_acc_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed({acc_w[31], acc_w}) <= $signed({2'b00, cfg_r.accel_limit})) &&
      ($signed({acc_w[31], acc_w}) >= -$signed({2'b00, cfg_r.accel_limit})))
    else $error("acceleration result outside the acceleration limit");

endmodule

`default_nettype wire

// ===== tb/axis_setpoint_accel_vel_limiter_tb.sv =====
// Testbench for axis_setpoint_accel_vel_limiter: sends setpoint steps for six
// axes, predicts every result with its own Q8.24 model and checks each field.
// Depends on spl_pkg and the RTL of the block; needs no files or arguments.
module axis_setpoint_accel_vel_limiter_tb import spl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AXES = 6;
  localparam logic [CFG_AW-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_SPARE_HI = 3'd7;
  localparam longint SP_MAX = 64'sh7FFF_FFFF;
  localparam longint SP_MIN = -64'sh8000_0000;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SELDOM, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic [2:0]  axis;
    logic [31:0] setpoint;
    logic [31:0] velocity;
    logic [31:0] accel;
  } step_result_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [63:0]       in_tdata = '0;   // measured_position, target_position
  logic [2:0]        in_tuser = '0;   // axis
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [95:0]       out_tdata;       // setpoint, velocity, acceleration
  logic [2:0]        out_tuser;       // axis_out
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [31:0]       cfg_wdata = '0;

  // Shadow of the block's registers and per-axis velocities
  logic [30:0] dt_q       = PERIOD_RST;
  logic [31:0] two_dtsq_q = TWO_OVER_PSQ_RST;
  logic [30:0] half_dtsq_q = HALF_PSQ_RST;
  logic [30:0] accel_lim_q = ACCEL_LIMIT_RST;
  logic [30:0] vel_lim_q  = VELOCITY_LIMIT_RST;
  logic [31:0] axis_vel [AXES] = '{default: '0};
  logic [31:0] track_pos [AXES] = '{default: '0};

  step_result_t expected_steps[$];
  int errors = 0;

  int burst_left = 0;
  bit tx_gaps = 1'b1;
  rx_mode_t rx_mode = RX_ALWAYS;
  int hold_req = 0;
  int hold_left = 0;
  int rx_tick = 0;

  axis_setpoint_accel_vel_limiter #(.AXES(AXES)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint sym_limit(input longint x, input logic [30:0] lim);
    longint l;
    l = lim;
    if (x > l) return l;
    if (x < -l) return -l;
    return x;
  endfunction

  // One control step: products are exact, >>> on signed values floors.
  function automatic step_result_t compute_step(input logic [2:0] ax,
                                                input logic [31:0] meas_in,
                                                input logic [31:0] targ_in);
    step_result_t r;
    longint meas, targ, v0, p, h, khi, klo, vdt, diff, acc, vnew, sp;
    meas = $signed(meas_in);
    targ = $signed(targ_in);
    v0   = $signed(axis_vel[ax]);
    p    = dt_q;
    h    = half_dtsq_q;
    khi  = two_dtsq_q[31:16];
    klo  = two_dtsq_q[15:0];
    vdt  = (v0 * p) >>> 24;
    diff = targ - meas - vdt;
    acc  = sym_limit(diff * khi + ((diff * klo) >>> 16), accel_lim_q);
    vnew = sym_limit(v0 + ((acc * p) >>> 24), vel_lim_q);
    sp   = meas + vdt + ((acc * h) >>> 24);
    if (sp > SP_MAX) sp = SP_MAX;
    if (sp < SP_MIN) sp = SP_MIN;
    axis_vel[ax] = vnew[31:0];
    r.axis     = ax;
    r.setpoint = sp[31:0];
    r.velocity = vnew[31:0];
    r.accel    = acc[31:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_scaled(input int min_shift);
    logic [31:0] x;
    x = $urandom;
    return $signed(x) >>> $urandom_range(min_shift, 31);
  endfunction

  function automatic logic [31:0] wild_reg();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Receiver: a long hold when asked, otherwise the current stall pattern
  always @(posedge clk) begin
    rx_tick++;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
        RX_SELDOM: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= ((rx_tick % 7) >= 3);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    step_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_steps.size() == 0) begin
        $display("%0t ns: result with nothing expected, expected none actual %h %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = expected_steps.pop_front();
        check_field("axis", want.axis, out_tuser);
        check_field("setpoint", want.setpoint, out_tdata[31:0]);
        check_field("velocity", want.velocity, out_tdata[63:32]);
        check_field("acceleration", want.accel, out_tdata[95:64]);
      end
    end
  end

  // Offer one item, idling between bursts, and predict it once accepted
  task automatic send_item(input logic [2:0] ax, input logic [31:0] meas,
                           input logic [31:0] targ);
    int gap;
    step_result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = tx_gaps ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= ax;
    in_tdata  <= {targ, meas};
    do @(posedge clk); while (!in_tready);
    if (ax < AXES) begin
      r = compute_step(ax, meas, targ);
      track_pos[ax] = r.setpoint;
      expected_steps.insert(expected_steps.size(), r);
    end
  endtask

  // Drop valid, wait for every result, then let the block go idle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_AW-1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PERIOD:         dt_q        = value[30:0];
      CFG_TWO_OVER_PSQ:   two_dtsq_q  = value;
      CFG_HALF_PSQ:       half_dtsq_q = value[30:0];
      CFG_ACCEL_LIMIT:    accel_lim_q = value[30:0];
      CFG_VELOCITY_LIMIT: vel_lim_q   = value[30:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_config(input logic [31:0] p, input logic [31:0] k,
                             input logic [31:0] h, input logic [31:0] amax,
                             input logic [31:0] vmax);
    write_cfg(CFG_PERIOD, p);
    write_cfg(CFG_TWO_OVER_PSQ, k);
    write_cfg(CFG_HALF_PSQ, h);
    write_cfg(CFG_ACCEL_LIMIT, amax);
    write_cfg(CFG_VELOCITY_LIMIT, vmax);
  endtask

  task automatic test_directed();
    send_item(0, 32'h0000_0000, 32'h0000_0000);
    // large positive error: acceleration clamps, velocity builds up
    send_item(0, 32'h0000_0000, 32'h0100_0000);
    send_item(0, 32'h0000_0000, 32'h0100_0000);
    send_item(1, 32'h0000_0000, 32'hFF00_0000);
    // huge error terms at both ends of the position range
    send_item(2, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(3, 32'h7FFF_FFFF, 32'h8000_0000);
    // setpoint saturates high, then low
    send_item(4, 32'h7FFF_FF00, 32'h7FFF_FFFF);
    send_item(5, 32'h8000_0010, 32'h8000_0000);
    // axes past the last one are dropped
    send_item(6, 32'h1234_5678, 32'h8765_4321);
    send_item(7, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(5, 32'h0010_0000, 32'h0010_0100);
    wait_idle();
    // tiny velocity limit: the clamp engages both ways
    write_cfg(CFG_VELOCITY_LIMIT, 32'd1000);
    repeat (4) send_item(0, 32'h0000_0000, 32'h0100_0000);
    repeat (2) send_item(0, 32'h0000_0000, 32'hFF00_0000);
    wait_idle();
    // zero acceleration limit forces zero acceleration
    write_cfg(CFG_ACCEL_LIMIT, 32'd0);
    send_item(1, 32'h0000_0000, 32'h0100_0000);
    send_item(2, 32'h7FFF_FFFF, 32'h8000_0000);
  endtask

  task automatic test_config_extremes();
    wait_idle();
    // all ones: the 31-bit registers drop their top bit
    load_config('1, '1, '1, '1, '1);
    write_cfg(CFG_SPARE_LO, 32'h1234_5678);
    write_cfg(CFG_SPARE_HI, 32'hFFFF_FFFF);
    repeat (8) send_item(3'($urandom_range(0, AXES - 1)), $urandom, $urandom);
    send_item(0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(1, 32'h7FFF_FFFF, 32'h8000_0000);
    wait_idle();
    load_config('0, '0, '0, '0, '0);
    repeat (4) send_item(3'($urandom_range(0, AXES - 1)), $urandom, $urandom);
    wait_idle();
    load_config(32'd1, 32'd1, 32'd0, '1, '1);
    repeat (6) send_item(3'($urandom_range(0, AXES - 1)), $urandom, $urandom);
    wait_idle();
    load_config(32'(PERIOD_RST), TWO_OVER_PSQ_RST, 32'(HALF_PSQ_RST),
                32'(ACCEL_LIMIT_RST), 32'(VELOCITY_LIMIT_RST));
  endtask

  task automatic test_backpressure();
    int n;
    rx_mode = RX_ALWAYS;
    tx_gaps = 1'b0;
    // receiver holds off while items keep coming; the block fills and stalls
    hold_req = 300;
    for (n = 0; n < 24; n++) send_item(3'(n % AXES), rand_scaled(8), rand_scaled(8));
    wait_idle();
    rx_mode = RX_PATTERN;
    for (n = 0; n < 12; n++) send_item(3'(n % AXES), rand_scaled(8), rand_scaled(8));
    wait_idle();
  endtask

  task automatic random_config(input bit wild);
    longint p;
    if (wild) begin
      load_config(wild_reg(), wild_reg(), wild_reg(), wild_reg(), wild_reg());
    end else begin
      // consistent set: dt between 1/16 s and 1 s
      p = $urandom_range(1 << 20, 1 << 24);
      load_config(32'(p), 32'((((64'sd1 << 62) / p) << 3) / p), 32'((p * p) >> 25),
                  $urandom_range(0, 1 << 26), $urandom_range(0, 1 << 27));
    end
  endtask

  task automatic test_random();
    int phase, n, pick;
    logic [2:0] ax;
    logic [31:0] meas, targ;
    for (phase = 0; phase < 8; phase++) begin
      wait_idle();
      if (phase != 0) random_config(phase % 3 == 2);
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      tx_gaps = (phase % 4 != 1);
      n = 0;
      while (n < 125) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) ax = 3'($urandom_range(AXES, 7));
        else ax = 3'($urandom_range(0, AXES - 1));
        if (pick <= 2 || ax >= AXES) begin
          meas = $urandom;
          targ = $urandom;
        end else begin
          // follow the trajectory: measure near the last setpoint, aim nearby
          meas = track_pos[ax] + rand_scaled(18);
          targ = meas + rand_scaled(4);
        end
        send_item(ax, meas, targ);
        if (ax < AXES) n++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    rx_mode = RX_MOSTLY;
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random();
    wait_idle();
    if (errors == 0 && expected_steps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== axis_setpoint_accel_vel_limiter.f =====
rtl/spl_pkg.sv
rtl/spl_ctrl.sv
rtl/spl_datapath.sv
rtl/axis_setpoint_accel_vel_limiter.sv
tb/axis_setpoint_accel_vel_limiter_tb.sv
